[rtl/tilt_pkg.sv]
package tilt_pkg;

    // Sample and result field widths.
    localparam int IN_W    = 16;
    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;

    // Magnitude path: squares, their sum, the scaled radicand and the root.
    localparam int PROD_W  = 31;
    localparam int SUM_W   = 32;
    localparam int FRAC_SH = 14;
    localparam int RAD_W   = SUM_W + 2 * FRAC_SH;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int SIDE_W  = 3 * IN_W;

    // CORDIC operand and angle accumulator widths (angle in 2^-16 degree).
    localparam int OP_W     = 34;
    localparam int Z_W      = 27;
    localparam int ROUND_SH = 9;
    localparam int TAB_LEN  = 24;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ROLL_MAX         = 23040;
    localparam int PITCH_MAX        = 11520;

    localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(11796480);

    // atan(2^-i) in units of 2^-16 degree, rounded.
    localparam logic signed [Z_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
        Z_W'(2949120), Z_W'(1740967), Z_W'(919879), Z_W'(466945),
        Z_W'(234379),  Z_W'(117304),  Z_W'(58666),  Z_W'(29335),
        Z_W'(14668),   Z_W'(7334),    Z_W'(3667),   Z_W'(1833),
        Z_W'(917),     Z_W'(458),     Z_W'(229),    Z_W'(115),
        Z_W'(57),      Z_W'(29),      Z_W'(14),     Z_W'(7),
        Z_W'(4),       Z_W'(2),       Z_W'(1),      Z_W'(0)
    };

endpackage

[rtl/tilt_isqrt.sv]
module tilt_isqrt
    import tilt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    // One result bit per stage: floor(sqrt(i_sum * 2^28)), restoring method.
    logic              r_valid [0:ROOT_W-1];
    logic [SUM_W-1:0]  r_sum   [0:ROOT_W-1];
    logic [REM_W-1:0]  r_rem   [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_root  [0:ROOT_W-1];
    logic [SIDE_W-1:0] r_side  [0:ROOT_W-1];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_step
        logic              w_valid_in;
        logic [SUM_W-1:0]  w_sum_in;
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [RAD_W-1:0]  w_rad;
        logic [REM_W-1:0]  w_cur;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;

        if (s == 0) begin : g_first
            assign w_valid_in = i_valid;
            assign w_sum_in   = i_sum;
            assign w_rem_in   = '0;
            assign w_root_in  = '0;
            assign w_side_in  = i_side;
        end else begin : g_next
            assign w_valid_in = r_valid[s-1];
            assign w_sum_in   = r_sum[s-1];
            assign w_rem_in   = r_rem[s-1];
            assign w_root_in  = r_root[s-1];
            assign w_side_in  = r_side[s-1];
        end

        // Bring down the next pair of radicand bits and try the new root bit.
        assign w_rad   = {w_sum_in, {(2 * FRAC_SH){1'b0}}};
        assign w_cur   = {w_rem_in[REM_W-3:0], w_rad[2 * (ROOT_W - 1 - s) +: 2]};
        assign w_trial = {1'b0, w_root_in, 2'b01};
        assign w_ge    = (w_cur >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (i_en) begin
                r_valid[s] <= w_valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sum[s]  <= w_sum_in;
                r_side[s] <= w_side_in;
                r_rem[s]  <= w_ge ? (w_cur - w_trial) : w_cur;
                r_root[s] <= {w_root_in[ROOT_W-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

[rtl/tilt_cordic.sv]
module tilt_cordic
    import tilt_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF,
    parameter int OUT_W = ROLL_W,
    parameter int LIMIT = ROLL_MAX
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [OP_W-1:0]  i_a,
    input  logic signed [OP_W-1:0]  i_b,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_angle
);

    localparam int NSTEP      = (STEPS < TAB_LEN) ? STEPS : TAB_LEN;
    localparam int Q_W        = Z_W - ROUND_SH;
    localparam int ROUND_HALF = 1 << (ROUND_SH - 1);
    localparam logic signed [Q_W-1:0] LIM_P = Q_W'(LIMIT);
    localparam logic signed [Q_W-1:0] LIM_N = -LIM_P;

    // Stage 0 holds the start vector; stage k holds it after k micro rotations.
    logic                   r_v [0:NSTEP];
    logic signed [OP_W-1:0] r_x [0:NSTEP];
    logic signed [OP_W-1:0] r_y [0:NSTEP];
    logic signed [Z_W-1:0]  r_z [0:NSTEP];

    logic signed [OP_W-1:0] n_x0;
    logic signed [OP_W-1:0] n_y0;
    logic signed [Z_W-1:0]  n_z0;

    // A vector in the left half plane is first turned by half a turn.
    always_comb begin
        if (i_b < 0) begin
            n_x0 = -i_b;
            n_y0 = -i_a;
            n_z0 = (i_a >= 0) ? HALF_TURN : -HALF_TURN;
        end else begin
            n_x0 = i_b;
            n_y0 = i_a;
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= n_x0;
            r_y[0] <= n_y0;
            r_z[0] <= n_z0;
        end
    end

    // Micro rotations; once the residual is zero the vector is left alone.
    for (genvar k = 0; k < NSTEP; k++) begin : g_rot
        logic signed [OP_W-1:0] w_xs;
        logic signed [OP_W-1:0] w_ys;
        logic signed [OP_W-1:0] n_x;
        logic signed [OP_W-1:0] n_y;
        logic signed [Z_W-1:0]  n_z;

        assign w_xs = r_x[k] >>> k;
        assign w_ys = r_y[k] >>> k;

        always_comb begin
            if (r_y[k] > 0) begin
                n_x = r_x[k] + w_ys;
                n_y = r_y[k] - w_xs;
                n_z = r_z[k] + ATAN_TAB[k];
            end else if (r_y[k] < 0) begin
                n_x = r_x[k] - w_ys;
                n_y = r_y[k] + w_xs;
                n_z = r_z[k] - ATAN_TAB[k];
            end else begin
                n_x = r_x[k];
                n_y = r_y[k];
                n_z = r_z[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1] <= n_x;
                r_y[k+1] <= n_y;
                r_z[k+1] <= n_z;
            end
        end
    end

    // Round half up to 1/128 degree, then saturate to the output range.
    logic signed [Z_W-1:0]   w_zr;
    logic signed [Q_W-1:0]   w_q;
    logic signed [Q_W-1:0]   w_sat;
    logic                    r_out_v;
    logic signed [OUT_W-1:0] r_angle;

    assign w_zr = r_z[NSTEP] + Z_W'(ROUND_HALF);
    assign w_q  = w_zr[Z_W-1:ROUND_SH];

    always_comb begin
        if (w_q > LIM_P) begin
            w_sat = LIM_P;
        end else if (w_q < LIM_N) begin
            w_sat = LIM_N;
        end else begin
            w_sat = w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= w_sat[OUT_W-1:0];
        end
    end

    assign o_valid = r_out_v;
    assign o_angle = r_angle;

endmodule

[rtl/accel_tilt_angles_unit.sv]
// Tilt angles (roll, pitch) from one three-axis accelerometer sample.
// Pipeline: three input stages, the 30-stage square root and the CORDIC stages
// (16 steps by default, at most 24 steps are carried out). Throughput: one transaction per
// cycle unless stalled; an output skid register keeps the pipeline moving while one waits,
// and o_stall is raised only when the skid register and the last stage are both full.
// Reset (synchronous, active low) clears all valid bits; data registers are not reset.
module accel_tilt_angles_unit
    import tilt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic signed [IN_W-1:0]    i_accel_x,
    input  logic signed [IN_W-1:0]    i_accel_y,
    input  logic signed [IN_W-1:0]    i_accel_z,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [ROLL_W-1:0]  o_roll_angle,
    output logic signed [PITCH_W-1:0] o_pitch_angle
);

    logic w_en;
    logic w_last_valid;
    logic w_pitch_valid;
    logic signed [ROLL_W-1:0]  w_roll;
    logic signed [PITCH_W-1:0] w_pitch;

    logic                  r_skid_valid;
    logic signed [ROLL_W-1:0]  r_skid_roll;
    logic signed [PITCH_W-1:0] r_skid_pitch;
    logic                  n_skid_valid;

    // The pipeline moves unless both the skid register and the last stage are full.
    assign w_en    = !r_skid_valid || !w_last_valid;
    assign o_stall = !w_en;

    // Input register.
    logic                   r_s0_valid;
    logic signed [IN_W-1:0] r_s0_x;
    logic signed [IN_W-1:0] r_s0_y;
    logic signed [IN_W-1:0] r_s0_z;

    // Squares of y and z.
    logic                   r_s1_valid;
    logic [PROD_W-1:0]      r_s1_yy;
    logic [PROD_W-1:0]      r_s1_zz;
    logic [SIDE_W-1:0]      r_s1_side;
    logic signed [2*IN_W-1:0] w_yy;
    logic signed [2*IN_W-1:0] w_zz;

    // Sum of squares.
    logic                   r_s2_valid;
    logic [SUM_W-1:0]       r_s2_sum;
    logic [SIDE_W-1:0]      r_s2_side;

    assign w_yy = r_s0_y * r_s0_y;
    assign w_zz = r_s0_z * r_s0_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_x    <= i_accel_x;
            r_s0_y    <= i_accel_y;
            r_s0_z    <= i_accel_z;
            r_s1_yy   <= w_yy[PROD_W-1:0];
            r_s1_zz   <= w_zz[PROD_W-1:0];
            r_s1_side <= {r_s0_x, r_s0_y, r_s0_z};
            r_s2_sum  <= SUM_W'(r_s1_yy) + SUM_W'(r_s1_zz);
            r_s2_side <= r_s1_side;
        end
    end

    // Magnitude of (y, z) in 2^-14 count units; the raw sample rides alongside.
    logic              w_mag_valid;
    logic [ROOT_W-1:0] w_mag;
    logic [SIDE_W-1:0] w_mag_side;

    tilt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_valid),
        .i_sum   (r_s2_sum),
        .i_side  (r_s2_side),
        .o_valid (w_mag_valid),
        .o_root  (w_mag),
        .o_side  (w_mag_side)
    );

    // CORDIC operands: counts scaled by 2^14.
    logic signed [IN_W-1:0] w_ax;
    logic signed [IN_W-1:0] w_ay;
    logic signed [IN_W-1:0] w_az;
    logic signed [OP_W-1:0] w_ax_ext;
    logic signed [OP_W-1:0] w_ay_ext;
    logic signed [OP_W-1:0] w_az_ext;
    logic signed [OP_W-1:0] w_roll_a;
    logic signed [OP_W-1:0] w_roll_b;
    logic signed [OP_W-1:0] w_pitch_a;
    logic signed [OP_W-1:0] w_pitch_b;

    assign w_ax      = w_mag_side[3*IN_W-1:2*IN_W];
    assign w_ay      = w_mag_side[2*IN_W-1:IN_W];
    assign w_az      = w_mag_side[IN_W-1:0];
    assign w_ax_ext  = OP_W'(w_ax);
    assign w_ay_ext  = OP_W'(w_ay);
    assign w_az_ext  = OP_W'(w_az);
    assign w_roll_a  = w_ay_ext <<< FRAC_SH;
    assign w_roll_b  = w_az_ext <<< FRAC_SH;
    assign w_pitch_a = -(w_ax_ext <<< FRAC_SH);
    assign w_pitch_b = $signed(OP_W'(w_mag));

    tilt_cordic #(
        .STEPS (CORDIC_STEPS),
        .OUT_W (ROLL_W),
        .LIMIT (ROLL_MAX)
    ) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mag_valid),
        .i_a     (w_roll_a),
        .i_b     (w_roll_b),
        .o_valid (w_last_valid),
        .o_angle (w_roll)
    );

    tilt_cordic #(
        .STEPS (CORDIC_STEPS),
        .OUT_W (PITCH_W),
        .LIMIT (PITCH_MAX)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_mag_valid),
        .i_a     (w_pitch_a),
        .i_b     (w_pitch_b),
        .o_valid (w_pitch_valid),
        .o_angle (w_pitch)
    );

    // Skid register: catches the last stage when the output is stalled.
    always_comb begin
        if (r_skid_valid) begin
            n_skid_valid = i_stall;
        end else begin
            n_skid_valid = w_last_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else begin
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid_roll  <= w_roll;
            r_skid_pitch <= w_pitch;
        end
    end

    // The skid register holds the older transaction, so it goes out first.
    assign o_valid       = r_skid_valid || w_last_valid;
    assign o_roll_angle  = r_skid_valid ? r_skid_roll : w_roll;
    assign o_pitch_angle = r_skid_valid ? r_skid_pitch : w_pitch;

    // Both angle pipelines carry the same transactions in step.
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last_valid == w_pitch_valid)
        else $error("roll and pitch pipelines out of step");

    // Results stay within their ranges.
    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_angle <= 16'sd23040 && o_roll_angle >= -16'sd23040))
        else $error("roll angle out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_angle <= 15'sd11520 && o_pitch_angle >= -15'sd11520))
        else $error("pitch angle out of range");

    // With both the skid register and the last stage full under a stall,
    // neither may be lost.
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && w_last_valid && i_stall) |=> (r_skid_valid && w_last_valid))
        else $error("result dropped while output stalled");

endmodule
